// ===== hw/rtl/apdu_record_store_defines.svh =====
// ----------------------------------------------------------------------------
// APDU record store assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef APDU_RECORD_STORE_DEFINES_SVH
`define APDU_RECORD_STORE_DEFINES_SVH

// same-cycle implication
`define ARS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ARS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ars_pkg.sv =====
// ----------------------------------------------------------------------------
// APDU record store package
// Types, codes and defaults shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ars_pkg;

   localparam int RECORDS_DEF      = 16;
   localparam int RECORD_BYTES_DEF = 64;
   localparam int LEN_W            = 6;
   localparam int HELD_W           = 5;

   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;
   localparam logic [1:0] ACT_DELETE = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_WRONG_LEN = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] record_number;
      logic [7:0] length;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        data_out;
      logic              data_valid;
      logic              final_res;
      logic [HELD_W-1:0] records_held;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_COMMIT,
      S_COMMIT_FIN,
      S_RD_LEN,
      S_RD_ADDR,
      S_RD_SEND,
      S_DEL_ROW,
      S_DEL_COPY,
      S_DEL_NEXT,
      S_DEL_FIN,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic check;
      logic commit_step;
      logic commit_fin;
      logic rd_load;
      logic stat_load;
      logic row_sel;
      logic copy_step;
      logic row_fin;
      logic del_fin;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       req_final;
      logic [1:0] act;
      logic       chk_ok;
      logic       commit_done;
      logic       copy_done;
      logic       row_more;
      logic       rd_zero;
      logic       rd_final;
      logic       rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ars_datapath.sv =====
// ----------------------------------------------------------------------------
// APDU record store datapath
// Staging buffer, record memory, length table, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_datapath
   import ars_pkg::*;
#(
   parameter int RECORDS      = RECORDS_DEF,
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int SLOT_W    = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int IDX_W     = $clog2(RECORD_BYTES);
   localparam int CNT_W     = $clog2(RECORDS + 1);
   localparam int STG_W     = $clog2(RECORD_BYTES + 1);
   localparam int ADDR_W    = SLOT_W + IDX_W;
   localparam int MEM_DEPTH = RECORDS << IDX_W;

   logic [7:0]        rec_mem [MEM_DEPTH];
   logic [7:0]        stg_mem [RECORD_BYTES];
   logic [LEN_W-1:0]  len_mem [RECORDS];

   req_type           item_ff, item_in;
   logic [STG_W-1:0]  staged_ff, staged_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic              wr_pend_ff, wr_pend_in;
   logic              wr_src_ff, wr_src_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [7:0]        sdata_ff;
   logic [7:0]        rdata_ff;
   logic [LEN_W-1:0]  len_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_is_write;
   logic              stage_en;
   logic              found;
   logic              full;
   logic              bad_len;
   logic [1:0]        chk_status;
   logic [SLOT_W-1:0] chk_slot;
   logic [SLOT_W-1:0] slot_next;
   logic [SLOT_W-1:0] row_slot;
   logic [ADDR_W-1:0] rec_raddr;
   logic [ADDR_W-1:0] rec_waddr;
   logic [7:0]        wr_data;
   logic [HELD_W-1:0] held;

   always_comb begin
      req_is_write = (req_data.action == ACT_CREATE) || (req_data.action == ACT_UPDATE);
      stage_en     = cmd.accept && req_is_write && (staged_ff < STG_W'(RECORD_BYTES));

      found   = (item_ff.record_number != 8'd0) &&
                (9'(item_ff.record_number) <= 9'(count_ff));
      full    = 9'(count_ff) >= 9'(RECORDS);
      bad_len = (item_ff.length == 8'd0) || (item_ff.length > 8'(RECORD_BYTES - 1));

      case (item_ff.action)
         ACT_CREATE: chk_status = full ? ST_FULL : (bad_len ? ST_WRONG_LEN : ST_OK);
         ACT_UPDATE: chk_status = !found ? ST_NOT_FOUND
                                         : (bad_len ? ST_WRONG_LEN : ST_OK);
         default:    chk_status = found ? ST_OK : ST_NOT_FOUND;
      endcase

      if (item_ff.action == ACT_CREATE) begin
         chk_slot = SLOT_W'(count_ff);
      end else begin
         chk_slot = SLOT_W'(item_ff.record_number - 8'd1);
      end

      slot_next = slot_ff + SLOT_W'(1);
      row_slot  = cmd.row_sel ? slot_next : slot_ff;
      rec_raddr = {row_slot, idx_ff};
      rec_waddr = {slot_ff, wr_idx_ff};
      if (wr_src_ff) begin
         // bytes past what was staged commit as zero
         wr_data = (STG_W'(wr_idx_ff) < staged_ff) ? sdata_ff : 8'h00;
      end else begin
         wr_data = rdata_ff;
      end
      held = HELD_W'(count_ff);
   end

   always_comb begin
      sts.req_final   = !req_is_write || req_data.last;
      sts.act         = item_ff.action;
      sts.chk_ok      = (chk_status == ST_OK);
      sts.commit_done = LEN_W'(idx_ff) == (item_ff.length[LEN_W-1:0] - LEN_W'(1));
      sts.copy_done   = idx_ff == IDX_W'(RECORD_BYTES - 1);
      sts.row_more    = (9'(slot_ff) + 9'd1) < 9'(count_ff);
      sts.rd_zero     = (len_q_ff == '0);
      sts.rd_final    = LEN_W'(idx_ff) == (len_q_ff - LEN_W'(1));
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      item_in    = item_ff;
      staged_in  = staged_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      wr_pend_in = cmd.commit_step || cmd.copy_step;
      wr_src_in  = cmd.commit_step;
      wr_idx_in  = idx_ff;
      rsp_in     = rsp_ff;

      if (cmd.accept) begin
         item_in = req_data;
         if (!req_is_write) begin
            staged_in = '0;
         end else if (stage_en) begin
            staged_in = staged_ff + STG_W'(1);
         end
      end

      if (cmd.check) begin
         status_in = chk_status;
         slot_in   = chk_slot;
         idx_in    = '0;
         if (chk_status != ST_OK) begin
            staged_in = '0;
         end
      end

      if (cmd.commit_step || cmd.copy_step || cmd.rd_load) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.commit_fin) begin
         staged_in = '0;
         if (item_ff.action == ACT_CREATE) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.row_fin) begin
         slot_in = slot_next;
         idx_in  = '0;
      end

      if (cmd.del_fin) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.rd_load) begin
         rsp_in = '{status: ST_OK, data_out: rdata_ff, data_valid: 1'b1,
                    final_res: sts.rd_final, records_held: held};
      end else if (cmd.stat_load) begin
         rsp_in = '{status: status_ff, data_out: 8'h00, data_valid: 1'b0,
                    final_res: 1'b1, records_held: held};
      end

      if (cmd.rd_load || cmd.stat_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         staged_ff    <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         staged_ff    <= staged_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      wr_src_ff <= wr_src_in;
      wr_idx_ff <= wr_idx_in;
      rsp_ff    <= rsp_in;
   end

   // staging buffer
   always_ff @(posedge clock) begin
      if (stage_en) begin
         stg_mem[staged_ff[IDX_W-1:0]] <= req_data.data_byte;
      end
      sdata_ff <= stg_mem[idx_ff];
   end

   // record bytes: one registered read, one write from the copy pipeline
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         rec_mem[rec_waddr] <= wr_data;
      end
      rdata_ff <= rec_mem[rec_raddr];
   end

   // record lengths
   always_ff @(posedge clock) begin
      if (cmd.commit_fin) begin
         len_mem[slot_ff] <= item_ff.length[LEN_W-1:0];
      end else if (cmd.row_fin) begin
         len_mem[slot_ff] <= len_q_ff;
      end
      len_q_ff <= len_mem[row_slot];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ars_ctrl.sv =====
// ----------------------------------------------------------------------------
// APDU record store controller
// Sequences staging, checks, commits, record reads and delete compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_ctrl
   import ars_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && sts.req_final) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.chk_ok) begin
               state_in = S_RESP;
            end else if (sts.act inside {ACT_CREATE, ACT_UPDATE}) begin
               state_in = S_COMMIT;
            end else if (sts.act == ACT_READ) begin
               state_in = S_RD_LEN;
            end else begin
               state_in = S_DEL_ROW;
            end
         end
         S_COMMIT: begin
            if (sts.commit_done) begin
               state_in = S_COMMIT_FIN;
            end
         end
         S_COMMIT_FIN: state_in = S_RESP;
         S_RD_LEN:     state_in = S_RD_ADDR;
         S_RD_ADDR: begin
            state_in = sts.rd_zero ? S_RESP : S_RD_SEND;
         end
         S_RD_SEND: begin
            if (sts.rsp_free) begin
               state_in = sts.rd_final ? S_IDLE : S_RD_ADDR;
            end
         end
         S_DEL_ROW: begin
            state_in = sts.row_more ? S_DEL_COPY : S_DEL_FIN;
         end
         S_DEL_COPY: begin
            if (sts.copy_done) begin
               state_in = S_DEL_NEXT;
            end
         end
         S_DEL_NEXT: state_in = S_DEL_ROW;
         S_DEL_FIN:  state_in = S_RESP;
         S_RESP: begin
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_CHECK:      cmd.check       = 1'b1;
         S_COMMIT:     cmd.commit_step = 1'b1;
         S_COMMIT_FIN: cmd.commit_fin  = 1'b1;
         S_RD_SEND:    cmd.rd_load     = sts.rsp_free;
         S_DEL_ROW:    cmd.row_sel     = 1'b1;
         S_DEL_COPY: begin
            cmd.row_sel   = 1'b1;
            cmd.copy_step = 1'b1;
         end
         S_DEL_NEXT: begin
            cmd.row_sel = 1'b1;
            cmd.row_fin = 1'b1;
         end
         S_DEL_FIN:    cmd.del_fin   = 1'b1;
         S_RESP:       cmd.stat_load = sts.rsp_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/apdu_record_store.sv =====
// ----------------------------------------------------------------------------
// APDU record store
// Linear record file: create, read, update and delete of byte records.
// ----------------------------------------------------------------------------
// Create and update payload items that are not marked last are staged at one
// per cycle and give no result. The final item of a create or update is
// checked, then copied at one byte per cycle from the staging buffer into the
// record memory; a rejected command goes from the check straight to its result.
// A read looks up the record length, then sends each byte from an address state
// and a send state around the registered read of the record memory. A delete
// moves every later record down one slot, row by row, then answers. The next
// transaction is taken once the last result is loaded into the output
// register; that register holds it while the consumer stalls.
`default_nettype none
`include "apdu_record_store_defines.svh"

module apdu_record_store
   import ars_pkg::*;
#(
   parameter int RECORDS      = RECORDS_DEF,
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   ars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ars_datapath #(
      .RECORDS      (RECORDS),
      .RECORD_BYTES (RECORD_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ARS_ASSERT_IMPL(a_data_is_success, rsp_valid && rsp_data.data_valid, rsp_data.status == ST_OK, "record byte with error status")
   `ARS_ASSERT_IMPL(a_error_is_final, rsp_valid && (rsp_data.status != ST_OK), rsp_data.final_res && !rsp_data.data_valid, "error result not single and final")
   `ARS_ASSERT_IMPL(a_one_action, 1'b1, $onehot0({cmd.accept, cmd.commit_step, cmd.copy_step, cmd.rd_load, cmd.stat_load}), "conflicting datapath commands")
   `ARS_ASSERT_NEXT(a_status_then_idle, cmd.stat_load, req_ready, "not ready after final status")

endmodule

`default_nettype wire
